FILE: rtl/mie_pkg.sv
`default_nettype none
package mie_pkg;

    localparam logic [31:0] HALT_WORD = 32'hFFFFFFFF;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0a;
    localparam logic [5:0] OP_SLTIU = 6'h0b;
    localparam logic [5:0] OP_ANDI  = 6'h0c;
    localparam logic [5:0] OP_ORI   = 6'h0d;
    localparam logic [5:0] OP_LUI   = 6'h0f;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_LBU   = 6'h24;
    localparam logic [5:0] OP_LHU   = 6'h25;
    localparam logic [5:0] OP_SB    = 6'h28;
    localparam logic [5:0] OP_SH    = 6'h29;
    localparam logic [5:0] OP_SW    = 6'h2b;
    localparam logic [5:0] OP_LL    = 6'h30;
    localparam logic [5:0] OP_SC    = 6'h38;

    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_JR    = 6'h08;
    localparam logic [5:0] FN_MFHI  = 6'h10;
    localparam logic [5:0] FN_MFLO  = 6'h12;
    localparam logic [5:0] FN_MULT  = 6'h18;
    localparam logic [5:0] FN_MULTU = 6'h19;
    localparam logic [5:0] FN_DIV   = 6'h1a;
    localparam logic [5:0] FN_DIVU  = 6'h1b;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_SUBU  = 6'h23;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_NOR   = 6'h27;
    localparam logic [5:0] FN_SLT   = 6'h2a;
    localparam logic [5:0] FN_SLTU  = 6'h2b;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch instruction word
        logic exec;      // registers read data valid, run the single-cycle ops
        logic md_start;  // start multiply/divide
        logic md_step;   // one iteration
        logic md_done;   // write HI/LO
        logic load_fin;  // memory read data ready
        logic out_load;  // load output register
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_md;
        logic is_load;
        logic md_last;
    } ctl_sts_t;

endpackage
`default_nettype wire

FILE: rtl/mie_ctrl.sv
`default_nettype none
module mie_ctrl
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire                  out_stall,
    input  wire mie_pkg::ctl_sts_t sts,
    output mie_pkg::ctl_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_EXEC = 6'b000100,
        ST_MD   = 6'b001000,
        ST_LOAD = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
                state_next = ST_EXEC;
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.is_md)
                begin
                    cmd.md_start = 1'b1;
                    state_next   = ST_MD;
                end
                else if (sts.is_load)
                    state_next = ST_LOAD;
                else
                    state_next = ST_FIN;
            end
            ST_MD:
            begin
                cmd.md_step = 1'b1;
                if (sts.md_last)
                    state_next = ST_FIN;
            end
            ST_LOAD:
            begin
                cmd.load_fin = 1'b1;
                state_next   = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.md_done    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.exec, cmd.md_step, cmd.load_fin, cmd.out_load}))
        else $error("overlapping commands");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_READ)
        else $error("capture did not start read");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg)
        else $error("result dropped under stall");
    a_md_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> state_reg == ST_FIN)
        else $error("output loaded outside finish");

endmodule
`default_nettype wire

FILE: rtl/mie_datapath.sv
`default_nettype none
module mie_datapath
#(
    parameter int DATA_WORDS      = 4096,
    parameter int TEXT_BASE_WORDS = 1048576
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire [31:0]           instr_word,
    input  wire mie_pkg::ctl_cmd_t cmd,
    output mie_pkg::ctl_sts_t    sts,
    output logic [29:0]          next_pc,
    output logic                 halted,
    output logic                 reg_write,
    output logic [4:0]           dest_reg,
    output logic [31:0]          dest_value
);

    localparam int AW = $clog2(DATA_WORDS);
    localparam logic [29:0] TBASE = 30'(TEXT_BASE_WORDS);

    logic [31:0] ir_reg;
    logic [31:0] regs_mem [32];
    logic [31:0] a_reg, b_reg;
    logic [31:0] data_mem [DATA_WORDS];
    logic [31:0] mrd_reg;
    logic [31:0] hi_reg, lo_reg;
    logic [29:0] pc_reg;

    logic        rwr_reg;
    logic [4:0]  rdst_reg;
    logic [31:0] rval_reg;
    logic [29:0] npc_reg;
    logic [31:0] addr_reg;

    logic [29:0] nxt_reg;
    logic        hlt_reg;
    logic        owr_reg;
    logic [4:0]  odst_reg;
    logic [31:0] oval_reg;

    // multiply/divide: 32 shift-add or restoring steps
    logic [5:0]  mcnt_reg;
    logic        mdiv_reg, mzero_reg, nega_reg, negb_reg;
    logic [63:0] acc_reg;
    logic [31:0] mb_reg, ma_reg;

    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] zimm, simm, addr;
    logic [29:0] pc1;

    assign op   = ir_reg[31:26];
    assign fn   = ir_reg[5:0];
    assign rs   = ir_reg[25:21];
    assign rt   = ir_reg[20:16];
    assign rd   = ir_reg[15:11];
    assign sh   = ir_reg[10:6];
    assign zimm = {16'h0000, ir_reg[15:0]};
    assign simm = {{16{ir_reg[15]}}, ir_reg[15:0]};
    assign addr = a_reg + simm;
    assign pc1  = pc_reg + 30'd1;

    assign sts.is_md   = (ir_reg != 32'h0) && (op == mie_pkg::OP_RTYPE) &&
                         (fn == mie_pkg::FN_MULT || fn == mie_pkg::FN_MULTU ||
                          fn == mie_pkg::FN_DIV  || fn == mie_pkg::FN_DIVU);
    assign sts.is_load = (ir_reg != mie_pkg::HALT_WORD) &&
                         (op == mie_pkg::OP_LW || op == mie_pkg::OP_LBU ||
                          op == mie_pkg::OP_LHU || op == mie_pkg::OP_LL);
    assign sts.md_last = (mcnt_reg == 6'd31);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            ir_reg <= instr_word;
        a_reg <= regs_mem[rs];
        b_reg <= regs_mem[rt];
        mrd_reg <= data_mem[addr[AW+1:2]];
    end

    logic        w_en;
    logic [4:0]  w_reg;
    logic [31:0] w_val;
    logic [29:0] w_pc;
    logic        w_st;
    logic [31:0] w_sdat;
    logic [3:0]  w_be;
    logic [31:0] jw;
    logic [31:0] link;

    always_comb
    begin
        w_en   = 1'b0;
        w_reg  = rd;
        w_val  = 32'h0;
        w_pc   = pc1;
        w_st   = 1'b0;
        w_sdat = b_reg;
        w_be   = 4'b1111;
        link   = {TBASE + pc1, 2'b00};
        jw     = {2'b00, ((TBASE + pc1) & 30'h3C000000) | {4'h0, ir_reg[25:0]}};
        if (ir_reg != 32'h0)
        begin
            case (op)
                mie_pkg::OP_RTYPE:
                begin
                    w_en = 1'b1;
                    case (fn)
                        mie_pkg::FN_ADD, mie_pkg::FN_ADDU: w_val = a_reg + b_reg;
                        mie_pkg::FN_SUB, mie_pkg::FN_SUBU: w_val = a_reg - b_reg;
                        mie_pkg::FN_AND:  w_val = a_reg & b_reg;
                        mie_pkg::FN_OR:   w_val = a_reg | b_reg;
                        mie_pkg::FN_NOR:  w_val = ~(a_reg | b_reg);
                        mie_pkg::FN_SLT:  w_val = {31'h0, $signed(a_reg) < $signed(b_reg)};
                        mie_pkg::FN_SLTU: w_val = {31'h0, a_reg < b_reg};
                        mie_pkg::FN_SLL:  w_val = b_reg << sh;
                        mie_pkg::FN_SRL:  w_val = b_reg >> sh;
                        mie_pkg::FN_SRA:  w_val = 32'($signed(b_reg) >>> sh);
                        mie_pkg::FN_MFHI: w_val = hi_reg;
                        mie_pkg::FN_MFLO: w_val = lo_reg;
                        mie_pkg::FN_JR:
                        begin
                            w_en = 1'b0;
                            w_pc = a_reg[31:2] - TBASE;
                        end
                        default: w_en = 1'b0;
                    endcase
                end
                mie_pkg::OP_J:   w_pc = jw[29:0] - TBASE;
                mie_pkg::OP_JAL:
                begin
                    w_pc  = jw[29:0] - TBASE;
                    w_en  = 1'b1;
                    w_reg = 5'd31;
                    w_val = link;
                end
                mie_pkg::OP_BEQ: if (a_reg == b_reg) w_pc = pc1 + simm[29:0];
                mie_pkg::OP_BNE: if (a_reg != b_reg) w_pc = pc1 + simm[29:0];
                mie_pkg::OP_ADDI, mie_pkg::OP_ADDIU:
                begin
                    w_en = 1'b1; w_reg = rt; w_val = a_reg + simm;
                end
                mie_pkg::OP_SLTI:
                begin
                    w_en = 1'b1; w_reg = rt;
                    w_val = {31'h0, $signed(a_reg) < $signed(simm)};
                end
                mie_pkg::OP_SLTIU:
                begin
                    w_en = 1'b1; w_reg = rt; w_val = {31'h0, a_reg < simm};
                end
                mie_pkg::OP_ANDI:
                begin
                    w_en = 1'b1; w_reg = rt; w_val = a_reg & zimm;
                end
                mie_pkg::OP_ORI:
                begin
                    w_en = 1'b1; w_reg = rt; w_val = a_reg | zimm;
                end
                mie_pkg::OP_LUI:
                begin
                    w_en = 1'b1; w_reg = rt; w_val = {ir_reg[15:0], 16'h0000};
                end
                mie_pkg::OP_LW, mie_pkg::OP_LL, mie_pkg::OP_LBU, mie_pkg::OP_LHU:
                begin
                    w_en = 1'b1; w_reg = rt;
                end
                mie_pkg::OP_SB:
                begin
                    w_st = 1'b1; w_sdat = {4{b_reg[7:0]}};
                    w_be = 4'b0001 << addr[1:0];
                end
                mie_pkg::OP_SH:
                begin
                    w_st = 1'b1; w_sdat = {2{b_reg[15:0]}};
                    w_be = addr[1] ? 4'b1100 : 4'b0011;
                end
                mie_pkg::OP_SW, mie_pkg::OP_SC: w_st = 1'b1;
                default: ;
            endcase
        end
        if (ir_reg == mie_pkg::HALT_WORD)
        begin
            w_en = 1'b0;
            w_st = 1'b0;
            w_pc = pc_reg;
        end
    end

    logic [31:0] ld_val;
    always_comb
    begin
        case (op)
            mie_pkg::OP_LBU: ld_val = {24'h0, 8'(mrd_reg >> {addr_reg[1:0], 3'b000})};
            mie_pkg::OP_LHU: ld_val = {16'h0, addr_reg[1] ? mrd_reg[31:16] : mrd_reg[15:0]};
            default:         ld_val = mrd_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rdst_reg <= w_reg;
            rval_reg <= w_val;
            npc_reg  <= w_pc;
            addr_reg <= addr;
            if (w_st)
                for (int i = 0; i < 4; i++)
                    if (w_be[i])
                        data_mem[addr[AW+1:2]][i*8 +: 8] <= w_sdat[i*8 +: 8];
        end
        if (cmd.load_fin)
            rval_reg <= ld_val;
        if (cmd.out_load)
        begin
            nxt_reg  <= npc_reg;
            hlt_reg  <= (ir_reg == mie_pkg::HALT_WORD);
            owr_reg  <= rwr_reg;
            odst_reg <= rwr_reg ? rdst_reg : 5'd0;
            oval_reg <= rwr_reg ? rval_reg : 32'h0;
        end
    end

    // register file writes, r0 kept at zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
                regs_mem[i] <= 32'h0;
            rwr_reg <= 1'b0;
            pc_reg  <= 30'h0;
        end
        else
        begin
            if (cmd.exec)
                rwr_reg <= w_en && (w_reg != 5'd0);
            if (cmd.out_load)
            begin
                pc_reg <= npc_reg;
                if (rwr_reg)
                    regs_mem[rdst_reg] <= rval_reg;
            end
        end
    end

    // iterative multiply / divide on magnitudes
    logic [32:0] dsub;
    logic [63:0] dsh;
    logic [31:0] mq, mr;
    logic [63:0] mp;
    assign dsh  = {acc_reg[62:0], 1'b0};
    // shifted partial remainder needs 33 bits for large unsigned divisors
    assign dsub = {acc_reg[63], dsh[63:32]} - {1'b0, mb_reg};
    assign mq   = acc_reg[31:0];
    assign mr   = acc_reg[63:32];
    assign mp   = (nega_reg ^ negb_reg) ? 64'h0 - acc_reg : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg   <= 32'h0;
            lo_reg   <= 32'h0;
            mcnt_reg <= 6'd0;
        end
        else
        begin
            if (cmd.md_start)
            begin
                mdiv_reg  <= fn[1];
                mzero_reg <= (b_reg == 32'h0);
                ma_reg    <= a_reg;
                nega_reg  <= !fn[0] && a_reg[31];
                negb_reg  <= !fn[0] && b_reg[31];
                mb_reg    <= (!fn[0] && b_reg[31]) ? 32'h0 - b_reg : b_reg;
                acc_reg   <= {32'h0, (!fn[0] && a_reg[31]) ? 32'h0 - a_reg : a_reg};
                mcnt_reg  <= 6'd0;
            end
            else if (cmd.md_step)
            begin
                mcnt_reg <= mcnt_reg + 6'd1;
                if (mdiv_reg)
                begin
                    if (!dsub[32])
                        acc_reg <= {dsub[31:0], dsh[31:1], 1'b1};
                    else
                        acc_reg <= dsh;
                end
                else
                begin
                    // shift-add, multiplier in low half shifts out
                    acc_reg <= {(acc_reg[0] ? {1'b0, acc_reg[63:32]} + {1'b0, mb_reg}
                                            : {1'b0, acc_reg[63:32]}), acc_reg[31:1]};
                end
            end
            if (cmd.md_done && sts.is_md)
            begin
                if (!mdiv_reg)
                begin
                    lo_reg <= mp[31:0];
                    hi_reg <= mp[63:32];
                end
                else if (mzero_reg)
                begin
                    lo_reg <= 32'hFFFFFFFF;
                    hi_reg <= ma_reg;
                end
                else
                begin
                    lo_reg <= (nega_reg ^ negb_reg) ? 32'h0 - mq : mq;
                    hi_reg <= nega_reg ? 32'h0 - mr : mr;
                end
            end
        end
    end

    assign next_pc    = nxt_reg;
    assign halted     = hlt_reg;
    assign reg_write  = owr_reg;
    assign dest_reg   = odst_reg;
    assign dest_value = oval_reg;

    a_r0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        regs_mem[0] == 32'h0) else $error("r0 written");
    a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && ir_reg == mie_pkg::HALT_WORD |-> npc_reg == pc_reg)
        else $error("halt moved pc");
    a_halt_nowr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && ir_reg == mie_pkg::HALT_WORD |-> !rwr_reg)
        else $error("halt wrote register");

endmodule
`default_nettype wire

FILE: rtl/mips32_integer_execute_unit.sv
// MIPS32 integer execute unit.
// Input channel: instr_word with in_valid / in_stall. Feed the word fetched at
// the last reported next_pc (zero after reset).
// Output channel: next_pc, halted, reg_write, dest_reg, dest_value with
// out_valid / out_stall; one result per instruction, in order.
// One instruction at a time: capture, register read, execute, finish.
// ALU, branch, jump and store go straight from execute to finish.
// Loads: a load step after execute (registered data memory read).
// mult/multu/div/divu: the 32 steps of the shift-add / restoring
// divide unit, after execute.
// The next instruction is taken once the previous result is registered.
// in_stall stays high while an instruction is in flight; a stalled result
// holds in the output register and the finish step waits for it to drain.
// Reset clears the registers, HI, LO and pc; data memory is not cleared and
// must be written before it is read.
`default_nettype none
module mips32_integer_execute_unit
#(
    parameter int DATA_WORDS      = 4096,
    parameter int TEXT_BASE_WORDS = 1048576
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [31:0] instr_word,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [29:0] next_pc,
    output logic        halted,
    output logic        reg_write,
    output logic [4:0]  dest_reg,
    output logic [31:0] dest_value
);

    mie_pkg::ctl_cmd_t cmd;
    mie_pkg::ctl_sts_t sts;

    mie_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    mie_datapath #(
        .DATA_WORDS      (DATA_WORDS),
        .TEXT_BASE_WORDS (TEXT_BASE_WORDS)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .instr_word (instr_word),
        .cmd        (cmd),
        .sts        (sts),
        .next_pc    (next_pc),
        .halted     (halted),
        .reg_write  (reg_write),
        .dest_reg   (dest_reg),
        .dest_value (dest_value)
    );

endmodule
`default_nettype wire

FILE: tb/mips32_integer_execute_unit_test.sv
`timescale 1ns / 100ps
`default_nettype none
module mips32_integer_execute_unit_test;

    localparam int MEM_WORDS   = 4096;
    localparam int TEXT_BASE   = 1048576;
    localparam int N_RANDOM    = 700;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_LEN    = 400;

    typedef struct packed {
        logic [29:0] npc;
        logic        hlt;
        logic        wr;
        logic [4:0]  rd;
        logic [31:0] val;
    } exec_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] instr_word;
    logic        out_valid;
    logic        out_stall;
    logic [29:0] next_pc;
    logic        halted;
    logic        reg_write;
    logic [4:0]  dest_reg;
    logic [31:0] dest_value;

    // architectural shadow state
    logic [31:0] gpr [32];
    logic [31:0] hi_val;
    logic [31:0] lo_val;
    logic [29:0] pc_val;
    logic [31:0] dmem [MEM_WORDS];
    logic [3:0]  dmem_set [MEM_WORDS];

    logic [31:0]  instr_q [$];
    exec_result_t result_q [$];

    int  errors;
    int  cycles;
    int  in_count;
    int  in_gap;
    int  out_gap;
    int  hold_cnt;
    bit  hold_done;
    bit  long_hold;
    bit  burst;
    logic in_fire;
    logic out_fire;

    mips32_integer_execute_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .instr_word (instr_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .next_pc    (next_pc),
        .halted     (halted),
        .reg_write  (reg_write),
        .dest_reg   (dest_reg),
        .dest_value (dest_value)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] rtype(logic [5:0] fn, int rs, int rt, int rd, int sh);
        rtype = {mie_pkg::OP_RTYPE, rs[4:0], rt[4:0], rd[4:0], sh[4:0], fn};
    endfunction

    function automatic logic [31:0] itype(logic [5:0] op, int rs, int rt, int imm);
        itype = {op, rs[4:0], rt[4:0], imm[15:0]};
    endfunction

    function automatic logic [31:0] mem_addr(logic [31:0] w);
        mem_addr = gpr[w[25:21]] + {{16{w[15]}}, w[15:0]};
    endfunction

    // loads of bytes never stored are turned into a word store at the same address
    function automatic logic [31:0] legalize_load(logic [31:0] w);
        logic [31:0] addr;
        logic [3:0]  need;
        addr = mem_addr(w);
        case (w[31:26])
            mie_pkg::OP_LBU:                need = 4'b0001 << addr[1:0];
            mie_pkg::OP_LHU:                need = addr[1] ? 4'b1100 : 4'b0011;
            mie_pkg::OP_LW, mie_pkg::OP_LL: need = 4'b1111;
            default:                        need = 4'b0000;
        endcase
        if ((dmem_set[addr[13:2]] & need) != need)
            w[31:26] = mie_pkg::OP_SW;
        legalize_load = w;
    endfunction

    function automatic exec_result_t run_instr(logic [31:0] w);
        exec_result_t r;
        logic [31:0] a, b, simm, zimm, addr, link;
        logic [29:0] nxt, seqw, tgt;
        logic [63:0] prod;
        longint      sa, sb;
        int          idx;
        r = '0;
        nxt = pc_val + 30'd1;
        if (w == mie_pkg::HALT_WORD)
        begin
            r.npc = pc_val;
            r.hlt = 1'b1;
            return r;
        end
        a = gpr[w[25:21]];
        b = gpr[w[20:16]];
        zimm = {16'h0, w[15:0]};
        simm = {{16{w[15]}}, w[15:0]};
        addr = a + simm;
        idx = addr[13:2];
        if (w != 32'h0)
        begin
            case (w[31:26])
                mie_pkg::OP_RTYPE:
                    case (w[5:0])
                        mie_pkg::FN_ADD, mie_pkg::FN_ADDU:
                            begin r.wr = 1; r.rd = w[15:11]; r.val = a + b; end
                        mie_pkg::FN_SUB, mie_pkg::FN_SUBU:
                            begin r.wr = 1; r.rd = w[15:11]; r.val = a - b; end
                        mie_pkg::FN_AND:  begin r.wr = 1; r.rd = w[15:11]; r.val = a & b; end
                        mie_pkg::FN_OR:   begin r.wr = 1; r.rd = w[15:11]; r.val = a | b; end
                        mie_pkg::FN_NOR:
                            begin r.wr = 1; r.rd = w[15:11]; r.val = ~(a | b); end
                        mie_pkg::FN_SLT:
                            begin r.wr = 1; r.rd = w[15:11]; r.val = $signed(a) < $signed(b); end
                        mie_pkg::FN_SLTU: begin r.wr = 1; r.rd = w[15:11]; r.val = a < b; end
                        mie_pkg::FN_SLL:
                            begin r.wr = 1; r.rd = w[15:11]; r.val = b << w[10:6]; end
                        mie_pkg::FN_SRL:
                            begin r.wr = 1; r.rd = w[15:11]; r.val = b >> w[10:6]; end
                        mie_pkg::FN_SRA:
                            begin r.wr = 1; r.rd = w[15:11]; r.val = $signed(b) >>> w[10:6]; end
                        mie_pkg::FN_MFHI: begin r.wr = 1; r.rd = w[15:11]; r.val = hi_val; end
                        mie_pkg::FN_MFLO: begin r.wr = 1; r.rd = w[15:11]; r.val = lo_val; end
                        mie_pkg::FN_JR:   nxt = a[31:2] - TEXT_BASE;
                        mie_pkg::FN_MULT:
                        begin
                            sa = $signed(a);
                            sb = $signed(b);
                            prod = sa * sb;
                            {hi_val, lo_val} = prod;
                        end
                        mie_pkg::FN_MULTU:
                        begin
                            prod = {32'h0, a} * {32'h0, b};
                            {hi_val, lo_val} = prod;
                        end
                        mie_pkg::FN_DIV, mie_pkg::FN_DIVU:
                            if (b == 0)
                            begin
                                lo_val = 32'hFFFFFFFF;
                                hi_val = a;
                            end
                            else if (w[5:0] == mie_pkg::FN_DIV)
                            begin
                                sa = $signed(a);
                                sb = $signed(b);
                                lo_val = 32'(sa / sb);
                                hi_val = 32'(sa % sb);
                            end
                            else
                            begin
                                lo_val = a / b;
                                hi_val = a % b;
                            end
                        default: ;
                    endcase
                mie_pkg::OP_J, mie_pkg::OP_JAL:
                begin
                    seqw = TEXT_BASE + pc_val + 1;
                    tgt = {seqw[29:26], w[25:0]};
                    if (w[31:26] == mie_pkg::OP_JAL)
                    begin
                        link = TEXT_BASE + pc_val + 1;
                        r.wr = 1; r.rd = 5'd31; r.val = link << 2;
                    end
                    nxt = tgt - TEXT_BASE;
                end
                mie_pkg::OP_BEQ:  if (a == b) nxt = pc_val + 1 + simm[29:0];
                mie_pkg::OP_BNE:  if (a != b) nxt = pc_val + 1 + simm[29:0];
                mie_pkg::OP_ADDI, mie_pkg::OP_ADDIU:
                    begin r.wr = 1; r.rd = w[20:16]; r.val = a + simm; end
                mie_pkg::OP_SLTI:
                    begin r.wr = 1; r.rd = w[20:16]; r.val = $signed(a) < $signed(simm); end
                mie_pkg::OP_SLTIU: begin r.wr = 1; r.rd = w[20:16]; r.val = a < simm; end
                mie_pkg::OP_ANDI:  begin r.wr = 1; r.rd = w[20:16]; r.val = a & zimm; end
                mie_pkg::OP_ORI:   begin r.wr = 1; r.rd = w[20:16]; r.val = a | zimm; end
                mie_pkg::OP_LUI:   begin r.wr = 1; r.rd = w[20:16]; r.val = zimm << 16; end
                mie_pkg::OP_LBU:
                begin
                    r.wr = 1; r.rd = w[20:16];
                    r.val = (dmem[idx] >> (8 * addr[1:0])) & 32'hFF;
                end
                mie_pkg::OP_LHU:
                begin
                    r.wr = 1; r.rd = w[20:16];
                    r.val = (dmem[idx] >> (16 * addr[1])) & 32'hFFFF;
                end
                mie_pkg::OP_LW, mie_pkg::OP_LL:
                    begin r.wr = 1; r.rd = w[20:16]; r.val = dmem[idx]; end
                mie_pkg::OP_SB:
                begin
                    dmem[idx][8*addr[1:0] +: 8] = b[7:0];
                    dmem_set[idx][addr[1:0]] = 1'b1;
                end
                mie_pkg::OP_SH:
                begin
                    dmem[idx][16*addr[1] +: 16] = b[15:0];
                    dmem_set[idx][2*addr[1] +: 2] = 2'b11;
                end
                mie_pkg::OP_SW, mie_pkg::OP_SC:
                begin
                    dmem[idx] = b;
                    dmem_set[idx] = 4'b1111;
                end
                default: ;
            endcase
        end
        if (r.wr && r.rd != 0)
            gpr[r.rd] = r.val;
        else
        begin
            r.wr = 0; r.rd = 0; r.val = 0;
        end
        pc_val = nxt;
        r.npc = nxt;
        return r;
    endfunction

    function automatic logic [31:0] random_instr();
        logic [5:0] ops [20] = '{mie_pkg::OP_RTYPE, mie_pkg::OP_RTYPE, mie_pkg::OP_RTYPE,
                                 mie_pkg::OP_J, mie_pkg::OP_JAL, mie_pkg::OP_BEQ,
                                 mie_pkg::OP_BNE, mie_pkg::OP_ADDI, mie_pkg::OP_ADDIU,
                                 mie_pkg::OP_SLTI, mie_pkg::OP_SLTIU, mie_pkg::OP_ANDI,
                                 mie_pkg::OP_ORI, mie_pkg::OP_LUI, mie_pkg::OP_LW,
                                 mie_pkg::OP_LBU, mie_pkg::OP_LHU, mie_pkg::OP_SB,
                                 mie_pkg::OP_SH, mie_pkg::OP_SW};
        logic [5:0] fns [19] = '{mie_pkg::FN_SLL, mie_pkg::FN_SRL, mie_pkg::FN_SRA,
                                 mie_pkg::FN_JR, mie_pkg::FN_MFHI, mie_pkg::FN_MFLO,
                                 mie_pkg::FN_MULT, mie_pkg::FN_MULTU, mie_pkg::FN_DIV,
                                 mie_pkg::FN_DIVU, mie_pkg::FN_ADD, mie_pkg::FN_ADDU,
                                 mie_pkg::FN_SUB, mie_pkg::FN_SUBU, mie_pkg::FN_AND,
                                 mie_pkg::FN_OR, mie_pkg::FN_NOR, mie_pkg::FN_SLT,
                                 mie_pkg::FN_SLTU};
        logic [31:0] w;
        logic [5:0]  op;
        int          sel;
        sel = $urandom_range(0, 99);
        w = $urandom;
        if (sel < 8)
            return w;
        if (sel < 11)
            return mie_pkg::HALT_WORD;
        if (sel < 14)
            return 32'h0;
        op = ops[$urandom_range(0, 19)];
        if (sel < 16)
            op = (sel == 14) ? mie_pkg::OP_LL : mie_pkg::OP_SC;
        w[31:26] = op;
        if (op == mie_pkg::OP_RTYPE)
            w[5:0] = fns[$urandom_range(0, 18)];
        if (op inside {mie_pkg::OP_LW, mie_pkg::OP_LBU, mie_pkg::OP_LHU, mie_pkg::OP_SB,
                       mie_pkg::OP_SH, mie_pkg::OP_SW, mie_pkg::OP_LL, mie_pkg::OP_SC}
            && $urandom_range(0, 3) != 0)
        begin
            // few base registers with small offsets so loads find stored data
            w[25:21] = $urandom_range(0, 3);
            w[15:0]  = $urandom_range(0, 63) - 32;
        end
        return legalize_load(w);
    endfunction

    task automatic queue_instr(logic [31:0] w);
        w = legalize_load(w);
        instr_q.push_back(w);
        result_q.push_back(run_instr(w));
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        in_fire <= in_valid && !in_stall;
        out_fire <= out_valid && !out_stall;
        if (in_valid && !in_stall)
            in_count <= in_count + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_q.size() == 0)
            begin
                report_mismatch("unexpected transfer", {2'b0, next_pc}, 32'h0);
            end
            else
            begin
                exec_result_t e;
                e = result_q.pop_front();
                if (next_pc !== e.npc)
                    report_mismatch("next_pc", 32'(next_pc), 32'(e.npc));
                if (halted !== e.hlt)
                    report_mismatch("halted", 32'(halted), 32'(e.hlt));
                if (reg_write !== e.wr)
                    report_mismatch("reg_write", 32'(reg_write), 32'(e.wr));
                if (dest_reg !== e.rd)
                    report_mismatch("dest_reg", 32'(dest_reg), 32'(e.rd));
                if (dest_value !== e.val)
                    report_mismatch("dest_value", dest_value, e.val);
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("mips32_integer_execute_unit regression: fail");
            $finish;
        end
    end

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (in_fire)
            begin
                if ($urandom_range(0, 49) == 0)
                    burst = !burst;
                in_gap = burst ? 0 : $urandom_range(0, 19);
            end
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (instr_q.size() > 0)
            begin
                instr_word <= instr_q.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // one long receiver hold-off while the sender keeps offering
    always @(negedge clk)
    begin
        if (!hold_done && in_count >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_cnt <= HOLD_LEN;
            long_hold <= 1'b1;
        end
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
        else
            long_hold <= 1'b0;
    end

    // output stall driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
                out_gap = burst ? 0 : $urandom_range(0, 19);
            else if (out_gap > 0)
                out_gap--;
            out_stall <= long_hold || (out_gap > 0);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        instr_word = 32'h0;
        out_stall = 1'b0;
        errors = 0;
        cycles = 0;
        in_count = 0;
        in_gap = 0;
        out_gap = 0;
        hold_cnt = 0;
        hold_done = 0;
        long_hold = 0;
        burst = 0;
        in_fire = 0;
        out_fire = 0;
        for (int i = 0; i < 32; i++)
            gpr[i] = 32'h0;
        hi_val = 0;
        lo_val = 0;
        pc_val = 0;
        for (int i = 0; i < MEM_WORDS; i++)
        begin
            dmem[i] = 32'h0;
            dmem_set[i] = 4'b0;
        end

        // directed: field extremes, every operation, corner cases
        queue_instr(32'h0);
        queue_instr(mie_pkg::HALT_WORD);
        queue_instr(mie_pkg::HALT_WORD);
        queue_instr(itype(mie_pkg::OP_LUI, 0, 1, 16'h7FFF));
        queue_instr(itype(mie_pkg::OP_ORI, 1, 1, 16'hFFFF));
        queue_instr(itype(mie_pkg::OP_ADDI, 1, 2, 1));                  // wraps
        queue_instr(itype(mie_pkg::OP_LUI, 0, 3, 16'h8000));
        queue_instr(itype(mie_pkg::OP_ADDIU, 0, 4, 16'hFFFF));
        queue_instr(rtype(mie_pkg::FN_ADD, 3, 4, 5, 0));
        queue_instr(rtype(mie_pkg::FN_SUB, 3, 1, 6, 0));
        queue_instr(rtype(mie_pkg::FN_SUBU, 0, 4, 6, 0));
        queue_instr(rtype(mie_pkg::FN_AND, 1, 3, 7, 0));
        queue_instr(rtype(mie_pkg::FN_OR, 1, 3, 7, 0));
        queue_instr(rtype(mie_pkg::FN_NOR, 1, 0, 7, 0));
        queue_instr(rtype(mie_pkg::FN_SLT, 3, 1, 8, 0));
        queue_instr(rtype(mie_pkg::FN_SLTU, 3, 1, 8, 0));
        queue_instr(rtype(mie_pkg::FN_SLL, 0, 4, 9, 31));
        queue_instr(rtype(mie_pkg::FN_SRL, 0, 4, 9, 31));
        queue_instr(rtype(mie_pkg::FN_SRA, 0, 3, 9, 31));
        queue_instr(rtype(mie_pkg::FN_MULT, 3, 4, 0, 0));
        queue_instr(rtype(mie_pkg::FN_MFHI, 0, 0, 10, 0));
        queue_instr(rtype(mie_pkg::FN_MULTU, 4, 4, 0, 0));
        queue_instr(rtype(mie_pkg::FN_MFLO, 0, 0, 11, 0));
        queue_instr(rtype(mie_pkg::FN_DIV, 3, 4, 0, 0));                // signed overflow
        queue_instr(rtype(mie_pkg::FN_MFLO, 0, 0, 11, 0));
        queue_instr(rtype(mie_pkg::FN_DIV, 1, 0, 0, 0));                // divide by zero
        queue_instr(rtype(mie_pkg::FN_MFHI, 0, 0, 10, 0));
        queue_instr(rtype(mie_pkg::FN_DIVU, 4, 1, 0, 0));
        queue_instr(rtype(mie_pkg::FN_MFHI, 0, 0, 10, 0));
        queue_instr(itype(mie_pkg::OP_SLTI, 3, 12, 16'h8000));
        queue_instr(itype(mie_pkg::OP_SLTIU, 0, 12, 16'hFFFF));
        queue_instr(itype(mie_pkg::OP_ANDI, 4, 12, 16'hFFFF));
        queue_instr(itype(mie_pkg::OP_SW, 0, 4, 4));
        queue_instr(itype(mie_pkg::OP_SB, 0, 1, 5));
        queue_instr(itype(mie_pkg::OP_SH, 0, 3, 7));                    // misaligned half
        queue_instr(itype(mie_pkg::OP_LBU, 0, 13, 5));
        queue_instr(itype(mie_pkg::OP_LHU, 0, 14, 7));
        queue_instr(itype(mie_pkg::OP_LW, 0, 15, 6));                   // misaligned word
        queue_instr(itype(mie_pkg::OP_SC, 0, 1, 4));
        queue_instr(itype(mie_pkg::OP_LL, 0, 16, 4));
        queue_instr(itype(mie_pkg::OP_BEQ, 0, 0, 16'hFFFF));
        queue_instr(itype(mie_pkg::OP_BNE, 1, 0, 3));
        queue_instr({mie_pkg::OP_J, 26'h3FFFFFF});
        queue_instr({mie_pkg::OP_JAL, 26'h5});
        queue_instr(rtype(mie_pkg::FN_JR, 31, 0, 0, 0));
        queue_instr(rtype(mie_pkg::FN_ADDU, 1, 1, 0, 0));               // r0 write dropped
        queue_instr({6'h11, 26'h1234567});                              // unknown opcode
        for (int i = 0; i < N_RANDOM; i++)
            queue_instr(random_instr());

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (instr_q.size() > 0 || result_q.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("mips32_integer_execute_unit regression: pass");
        else
            $display("mips32_integer_execute_unit regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
